[hdl/mcasm_pkg.sv]
package mcasm_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] TOP_BIT   = 8'h80;
	localparam logic [7:0] MASK_C0   = 8'hc0;
	localparam logic [7:0] MASK_E0   = 8'he0;
	localparam logic [7:0] MASK_F0   = 8'hf0;
	localparam logic [7:0] LEAD_F8   = 8'hf8;
	localparam logic [7:0] CONT_PAT  = 8'h80;
	localparam logic [7:0] LEAD2_PAT = 8'hc0;
	localparam logic [7:0] LEAD3_PAT = 8'he0;
	localparam logic [7:0] QMARK     = 8'h3f;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_SJIS   = 2'd1,
		MODE_UTF8   = 2'd2,
		MODE_UTF16  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NORMAL  = 2'd0,
		KIND_INVALID = 2'd1,
		KIND_TRUNC   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// one queue entry: a character, optionally followed by an end marker
	typedef struct packed {
		logic [31:0] code;
		logic [2:0]  len;
		kind_t       kind;
		logic        with_end;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hdl/mcasm_front.sv]
module mcasm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       encoding_mode,
	input  mcasm_pkg::q_stat_t q_stat,
	output logic             push,
	output mcasm_pkg::job_t  push_job
);
	import mcasm_pkg::*;

	mode_t       mode_q;
	logic [31:0] acc_q;
	logic [1:0]  rem_q;
	logic [2:0]  gath_q;

	logic        accept;
	logic        job_vld;
	job_t        job;
	logic [31:0] acc_d;
	logic [1:0]  rem_d;
	logic [2:0]  gath_d;
	logic [31:0] acc_ext;
	logic [2:0]  gath_inc;
	logic [1:0]  rem_dec;
	logic [31:0] byte_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;
	assign accept    = in_valid && !in_stall;

	assign byte_ext = {24'd0, data_byte};
	assign gath_inc = gath_q + 3'd1;
	assign rem_dec  = rem_q - 2'd1;

	always_comb begin
		if (mode_q == MODE_UTF16)
			acc_ext = acc_q | {16'd0, data_byte, 8'd0};
		else
			acc_ext = {acc_q[23:0], data_byte};
	end

	always_comb begin
		job_vld = 1'b0;
		job     = '{code: byte_ext, len: 3'd1, kind: KIND_NORMAL, with_end: 1'b0};
		acc_d   = acc_q;
		rem_d   = rem_q;
		gath_d  = gath_q;
		if (rem_q != 2'd0) begin
			if (mode_q == MODE_UTF8 && data_byte == 8'd0) begin
				job_vld = 1'b1;
				job     = '{code: acc_q, len: gath_q, kind: KIND_TRUNC, with_end: 1'b1};
				acc_d   = '0;
				rem_d   = '0;
				gath_d  = '0;
			end else if (rem_dec == 2'd0) begin
				job_vld = 1'b1;
				job     = '{code: acc_ext, len: gath_inc, kind: KIND_NORMAL, with_end: 1'b0};
				acc_d   = '0;
				rem_d   = '0;
				gath_d  = '0;
			end else begin
				acc_d  = acc_ext;
				rem_d  = rem_dec;
				gath_d = gath_inc;
			end
		end else begin
			unique case (mode_q)
				MODE_SINGLE: begin
					job_vld = 1'b1;
				end
				MODE_SJIS: begin
					if ((data_byte & TOP_BIT) != 8'd0) begin
						acc_d  = byte_ext;
						gath_d = 3'd1;
						rem_d  = 2'd1;
					end else begin
						job_vld = 1'b1;
					end
				end
				MODE_UTF8: begin
					if (data_byte == 8'd0) begin
						job_vld = 1'b1;
						job     = '{code: 32'd0, len: 3'd0, kind: KIND_END, with_end: 1'b0};
					end else if ((data_byte & TOP_BIT) == 8'd0) begin
						job_vld = 1'b1;
					end else if ((data_byte & MASK_C0) == CONT_PAT || data_byte >= LEAD_F8) begin
						job_vld = 1'b1;
						job     = '{code: {24'd0, QMARK}, len: 3'd1, kind: KIND_INVALID,
						            with_end: 1'b0};
					end else begin
						acc_d  = byte_ext;
						gath_d = 3'd1;
						if ((data_byte & MASK_E0) == LEAD2_PAT)
							rem_d = 2'd1;
						else if ((data_byte & MASK_F0) == LEAD3_PAT)
							rem_d = 2'd2;
						else
							rem_d = 2'd3;
					end
				end
				MODE_UTF16: begin
					if (data_byte == 8'd0) begin
						job_vld = 1'b1;
						job     = '{code: 32'd0, len: 3'd0, kind: KIND_END, with_end: 1'b0};
					end else begin
						acc_d  = byte_ext;
						gath_d = 3'd1;
						rem_d  = 2'd1;
					end
				end
				default: begin
					job_vld = 1'b0;
				end
			endcase
		end
	end

	assign push     = accept && job_vld;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
			acc_q  <= '0;
			rem_q  <= '0;
			gath_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// mode change drops any partial character
			mode_q <= mode_t'(encoding_mode);
			acc_q  <= '0;
			rem_q  <= '0;
			gath_q <= '0;
		end else if (accept) begin
			acc_q  <= acc_d;
			rem_q  <= rem_d;
			gath_q <= gath_d;
		end
	end

endmodule

[hdl/mcasm_fifo.sv]
module mcasm_fifo #(
	parameter int DEPTH = mcasm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mcasm_pkg::job_t    push_job,
	input  logic               pop,
	output mcasm_pkg::job_t    pop_job,
	output mcasm_pkg::q_stat_t q_stat
);
	import mcasm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign pop_job      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

[hdl/mcasm_back.sv]
module mcasm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mcasm_pkg::q_stat_t q_stat,
	input  mcasm_pkg::job_t    pop_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        char_code,
	output logic [2:0]         char_length,
	output logic [1:0]         char_kind,
	output logic               last_result
);
	import mcasm_pkg::*;

	logic        out_valid_q;
	logic        pend_end_q;
	logic [31:0] code_q;
	logic [2:0]  len_q;
	kind_t       kind_q;
	logic        last_q;
	logic        load;

	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !pend_end_q && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_end_q  <= 1'b0;
		end else if (load) begin
			if (pend_end_q) begin
				out_valid_q <= 1'b1;
				pend_end_q  <= 1'b0;
			end else if (!q_stat.empty) begin
				out_valid_q <= 1'b1;
				pend_end_q  <= pop_job.with_end;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_end_q) begin
				code_q <= '0;
				len_q  <= '0;
				kind_q <= KIND_END;
				last_q <= 1'b1;
			end else begin
				code_q <= pop_job.code;
				len_q  <= pop_job.len;
				kind_q <= pop_job.kind;
				last_q <= !pop_job.with_end;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign char_code   = code_q;
	assign char_length = len_q;
	assign char_kind   = kind_q;
	assign last_result = last_q;

	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_end_q |-> out_valid_q)
		else $error("end marker pending without a shown result");

	a_not_last_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> pend_end_q && kind_q == KIND_TRUNC)
		else $error("non-final result without a following end marker");

	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_end_q && load |=> out_valid_q && kind_q == KIND_END && last_q)
		else $error("end marker did not follow truncated character");

endmodule

[hdl/multi_encoding_char_assembler_core.sv]
// Splits a byte stream into characters under the mode held in encoding_mode
// (0 single byte, 1 Shift-JIS, 2 UTF-8, 3 UTF-16 byte pairs; reset UTF-8).
// Each result carries the character's bytes packed earliest-first (UTF-16:
// first byte low), its length and a kind; last_result marks the final result
// of an input byte. One byte is accepted per cycle unless in_stall is high and
// one result leaves per cycle unless out_stall is high; the front classifies
// a byte combinationally and a queue of QUEUE_DEPTH entries feeds the output
// register. A zero byte that truncates a UTF-8 character gives two results;
// the queue absorbs that, and in_stall rises only when the queue is full. A
// configuration write is taken at once and clears any partial character.
module multi_encoding_char_assembler_core #(
	parameter int QUEUE_DEPTH = mcasm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  encoding_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] char_code,
	output logic [2:0]  char_length,
	output logic [1:0]  char_kind,
	output logic        last_result
);
	import mcasm_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    pop_job;

	mcasm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.encoding_mode(encoding_mode),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	mcasm_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_stat  (q_stat)
	);

	mcasm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_job    (pop_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.char_length(char_length),
		.char_kind  (char_kind),
		.last_result(last_result)
	);

endmodule

[tb/sv/multi_encoding_char_assembler_core_test.sv]
`timescale 1ns / 1ps

module multi_encoding_char_assembler_core_test;
	import mcasm_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 110;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic [31:0] code;
		logic [2:0]  len;
		kind_t       kind;
		logic        last;
	} char_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CHECKED,
		ROW_MODE
	} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic [7:0]  val;
		logic [31:0] code;
		logic [2:0]  len;
		kind_t       kind;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  encoding_mode;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] char_code;
	logic [2:0]  char_length;
	logic [1:0]  char_kind;
	logic        last_result;

	multi_encoding_char_assembler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.encoding_mode(encoding_mode),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_code    (char_code),
		.char_length  (char_length),
		.char_kind    (char_kind),
		.last_result  (last_result)
	);

	// predictor state
	mode_t       cur_mode;
	logic [31:0] acc_code;
	logic [1:0]  need_bytes;
	logic [2:0]  have_bytes;

	char_t       chars_due[$];
	logic [7:0]  plan[$];
	stim_row_t   directed[$];

	int  mismatches = 0;
	int  chars_checked = 0;
	int  bytes_sent = 0;
	int  mode_writes = 0;
	int  input_stall_cycles = 0;
	int  cycle_count = 0;
	int  stall_pct = 0;
	bit  gaps_on = 1'b0;
	bit  hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic stim_row_t row(row_op_t op, logic [7:0] val, logic [31:0] code,
			logic [2:0] len, kind_t kind);
		stim_row_t r;
		r.op = op;
		r.val = val;
		r.code = code;
		r.len = len;
		r.kind = kind;
		return r;
	endfunction

	task automatic emit(input bit record, input logic [31:0] code, input logic [2:0] len,
			input kind_t kind, input logic last);
		char_t c;
		c.code = code;
		c.len = len;
		c.kind = kind;
		c.last = last;
		if (record)
			chars_due.push_back(c);
	endtask

	task automatic clear_char();
		acc_code = '0;
		need_bytes = '0;
		have_bytes = '0;
	endtask

	// advances the character state by one byte; record=0 updates state only
	task automatic assemble(input logic [7:0] b, input bit record);
		if (need_bytes != 0) begin
			if (cur_mode == MODE_UTF8 && b == 8'h00) begin
				emit(record, acc_code, have_bytes, KIND_TRUNC, 1'b0);
				emit(record, '0, '0, KIND_END, 1'b1);
				clear_char();
			end else begin
				if (cur_mode == MODE_UTF16)
					acc_code = acc_code | {16'h0, b, 8'h0};
				else
					acc_code = {acc_code[23:0], b};
				have_bytes = have_bytes + 3'd1;
				need_bytes = need_bytes - 2'd1;
				if (need_bytes == 0) begin
					emit(record, acc_code, have_bytes, KIND_NORMAL, 1'b1);
					clear_char();
				end
			end
		end else begin
			case (cur_mode)
				MODE_SINGLE: emit(record, {24'h0, b}, 3'd1, KIND_NORMAL, 1'b1);
				MODE_SJIS: begin
					if (b[7]) begin
						acc_code = {24'h0, b};
						have_bytes = 3'd1;
						need_bytes = 2'd1;
					end else begin
						emit(record, {24'h0, b}, 3'd1, KIND_NORMAL, 1'b1);
					end
				end
				MODE_UTF8: begin
					if (b == 8'h00) begin
						emit(record, '0, '0, KIND_END, 1'b1);
					end else if (!b[7]) begin
						emit(record, {24'h0, b}, 3'd1, KIND_NORMAL, 1'b1);
					end else if (b[7:6] == 2'b10 || b >= LEAD_F8) begin
						emit(record, {24'h0, QMARK}, 3'd1, KIND_INVALID, 1'b1);
					end else begin
						acc_code = {24'h0, b};
						have_bytes = 3'd1;
						if (b[7:5] == 3'b110)
							need_bytes = 2'd1;
						else if (b[7:4] == 4'b1110)
							need_bytes = 2'd2;
						else
							need_bytes = 2'd3;
					end
				end
				default: begin
					if (b == 8'h00) begin
						emit(record, '0, '0, KIND_END, 1'b1);
					end else begin
						acc_code = {24'h0, b};
						have_bytes = 3'd1;
						need_bytes = 2'd1;
					end
				end
			endcase
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed, input char_t want);
		int g;
		g = pick_gap();
		repeat (g) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		assemble(b, !typed);
		if (typed)
			chars_due.push_back(want);
		bytes_sent++;
	endtask

	// a lead byte leaves nothing to wait for, so keep waiting past the last result
	task automatic wait_drained();
		while (chars_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		encoding_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cur_mode = m;
		clear_char();
		mode_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] utf8_lead(int n);
		case (n)
			1: return 8'($urandom_range(1, 127));
			2: return 8'h c0 | 8'($urandom_range(0, 31));
			3: return 8'h e0 | 8'($urandom_range(0, 15));
			default: return 8'h f0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	// continuation bytes are not checked by the block, so now and then any nonzero byte
	function automatic logic [7:0] utf8_cont();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(1, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	task automatic add_char(input mode_t m);
		int r;
		int n;
		int k;
		r = $urandom_range(0, 99);
		case (m)
			MODE_SINGLE: plan.push_back(r < 5 ? 8'h00 : 8'($urandom_range(0, 255)));
			MODE_SJIS: begin
				if (r < 50) begin
					plan.push_back(8'h80 | 8'($urandom_range(0, 127)));
					plan.push_back(r < 5 ? 8'h00 : 8'($urandom_range(0, 255)));
				end else begin
					plan.push_back(8'($urandom_range(0, 127)));
				end
			end
			MODE_UTF8: begin
				if (r < 60) begin
					n = $urandom_range(1, 4);
					plan.push_back(utf8_lead(n));
					for (k = 1; k < n; k++)
						plan.push_back(utf8_cont());
				end else if (r < 68) begin
					plan.push_back(8'h00);
				end else if (r < 78) begin
					// string ends inside a character
					n = $urandom_range(2, 4);
					plan.push_back(utf8_lead(n));
					k = $urandom_range(0, n - 2);
					repeat (k) plan.push_back(utf8_cont());
					plan.push_back(8'h00);
				end else if (r < 88) begin
					if (r < 83)
						plan.push_back(8'h80 | 8'($urandom_range(0, 63)));
					else
						plan.push_back(8'h f8 | 8'($urandom_range(0, 7)));
				end else begin
					plan.push_back(8'($urandom_range(0, 255)));
				end
			end
			default: begin
				if (r < 10) begin
					plan.push_back(8'h00);
				end else begin
					plan.push_back(8'($urandom_range(1, 255)));
					plan.push_back(r < 15 ? 8'h00 : 8'($urandom_range(0, 255)));
				end
			end
		endcase
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		char_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d characters outstanding", $time, chars_due.size());
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && in_valid && in_stall)
			input_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (chars_due.size() == 0) begin
				$display("%0t: unexpected transfer code=%0h len=%0d kind=%0d last=%0b",
					$time, char_code, char_length, char_kind, last_result);
				mismatches++;
			end else begin
				want = chars_due.pop_front();
				check_field("char_code", want.code, char_code);
				check_field("char_length", 32'(want.len), 32'(char_length));
				check_field("char_kind", 32'(want.kind), 32'(char_kind));
				check_field("last_result", 32'(want.last), 32'(last_result));
				chars_checked++;
			end
		end
	end

	initial begin
		char_t want;
		mode_t m;
		int phase;
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		cfg_valid = 1'b0;
		encoding_mode = MODE_UTF8;
		cur_mode = MODE_UTF8;
		clear_char();

		// reset mode is UTF-8
		directed.push_back(row(ROW_CHECKED, 8'h00, 32'h0, 3'd0, KIND_END));
		directed.push_back(row(ROW_CHECKED, 8'h7f, 32'h7f, 3'd1, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'h80, {24'h0, QMARK}, 3'd1, KIND_INVALID));
		directed.push_back(row(ROW_CHECKED, 8'hf8, {24'h0, QMARK}, 3'd1, KIND_INVALID));
		directed.push_back(row(ROW_CHECKED, 8'hff, {24'h0, QMARK}, 3'd1, KIND_INVALID));
		directed.push_back(row(ROW_BYTE, 8'hc3, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'ha9, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'hf0, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h9f, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h98, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h80, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'he2, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h81, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h00, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_MODE, 8'(MODE_SINGLE), '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'h00, 32'h0, 3'd1, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'hff, 32'hff, 3'd1, KIND_NORMAL));
		directed.push_back(row(ROW_MODE, 8'(MODE_SJIS), '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'h41, 32'h41, 3'd1, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h81, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h00, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'hff, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'hff, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_MODE, 8'(MODE_UTF16), '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'h00, 32'h0, 3'd0, KIND_END));
		directed.push_back(row(ROW_BYTE, 8'h34, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h12, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h01, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_BYTE, 8'h00, '0, '0, KIND_NORMAL));
		// partial pair is dropped by the mode write
		directed.push_back(row(ROW_BYTE, 8'hab, '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_MODE, 8'(MODE_UTF8), '0, '0, KIND_NORMAL));
		directed.push_back(row(ROW_CHECKED, 8'h41, 32'h41, 3'd1, KIND_NORMAL));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gaps_on = 1'b1;
		stall_pct = 25;
		foreach (directed[i]) begin
			if (directed[i].op == ROW_MODE) begin
				set_mode(mode_t'(directed[i].val[1:0]));
			end else begin
				want.code = directed[i].code;
				want.len = directed[i].len;
				want.kind = directed[i].kind;
				want.last = 1'b1;
				send_byte(directed[i].val, directed[i].op == ROW_CHECKED, want);
			end
		end

		want = '0;
		for (phase = 0; phase < PHASES; phase++) begin
			m = (phase < 8) ? mode_t'(phase % 4) : mode_t'($urandom_range(0, 3));
			set_mode(m);
			gaps_on = (phase % 3 != 2);
			stall_pct = (phase % 4 == 1) ? 0 : ((phase % 4 == 3) ? 50 : 20);
			if (phase == 5) begin
				// sender keeps going while the receiver holds off
				gaps_on = 1'b0;
				hold_req = 1'b1;
			end
			plan.delete();
			while (plan.size() < PHASE_ITEMS)
				add_char(m);
			for (i = 0; i < plan.size(); i++) begin
				if (phase == 7 && i == plan.size() / 2) begin
					@(negedge clk);
					in_valid <= 1'b0;
					while (chars_due.size() != 0)
						@(posedge clk);
				end
				send_byte(plan[i], 1'b0, want);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes across %0d encoding writes, checked %0d characters;",
			bytes_sent, mode_writes, chars_checked);
		$display("input was held back on %0d cycles.", input_stall_cycles);
		if (mismatches == 0 && chars_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d characters never seen", mismatches, chars_due.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[multi_encoding_char_assembler_core.f]
hdl/mcasm_pkg.sv
hdl/mcasm_front.sv
hdl/mcasm_fifo.sv
hdl/mcasm_back.sv
hdl/multi_encoding_char_assembler_core.sv
tb/sv/multi_encoding_char_assembler_core_test.sv
